[design/jcbc_pkg.sv]
package jcbc_pkg;

	localparam int PendingDepth = 32;
	localparam int TableDepth   = 64;
	localparam int PayloadBytes = 4096;

	localparam int PendW  = $clog2(PendingDepth);
	localparam int CntW   = $clog2(PendingDepth + 1);
	localparam int TblW   = $clog2(TableDepth);
	localparam int HeldW  = $clog2(TableDepth + 1);
	localparam int PosW   = 17;
	localparam int BlkW   = 32;
	localparam int HalfW  = 16;

	localparam logic [PosW-1:0]  SCAN_START     = PosW'(8);
	localparam logic [HalfW-1:0] HDR_BYTES      = HalfW'(4);
	localparam logic [HalfW-1:0] DATA_REC_BYTES = HalfW'(8 + PayloadBytes);
	localparam logic [HalfW-1:0] TYPE_DATA      = HalfW'(1);
	localparam logic [HalfW-1:0] TYPE_COMMIT    = HalfW'(2);
	localparam logic [HeldW-1:0] TABLE_LIMIT    = HeldW'(TableDepth);

	localparam logic REG_USED_BYTES = 1'b0;
	localparam logic REG_TABLE_CAP  = 1'b1;

	typedef enum logic [2:0] {
		ST_QUEUED    = 3'd0,
		ST_COMMITTED = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_STOPPED   = 3'd3,
		ST_IGNORED   = 3'd4,
		ST_DROPPED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		RS_NONE      = 3'd0,
		RS_PAST_END  = 3'd1,
		RS_TOO_SMALL = 3'd2,
		RS_OVERRUN   = 3'd3,
		RS_BAD_SIZE  = 3'd4,
		RS_PEND_FULL = 3'd5,
		RS_UNKNOWN   = 3'd6
	} reason_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CHECK,
		SQ_RD_PEND,
		SQ_LOAD_BLK,
		SQ_SEARCH,
		SQ_PLACE,
		SQ_EMIT
	} seq_state_t;

	typedef struct packed {
		status_t            status;
		reason_t            reason;
		logic [BlkW-1:0]    block;
		logic [PendW-1:0]   pslot;
		logic [TblW-1:0]    tslot;
		logic [HeldW-1:0]   held;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [TblW-1:0] rd_addr;
		logic            wr_en;
		logic [TblW-1:0] wr_addr;
		logic [BlkW-1:0] wr_data;
	} tbl_req_t;

endpackage

[design/jcbc_table.sv]
module jcbc_table (
	input  logic                    clk,
	input  jcbc_pkg::tbl_req_t      req,
	input  logic [31:0]             key,
	output logic                    hit
);
	import jcbc_pkg::*;

	logic [BlkW-1:0] mem [TableDepth];
	logic [BlkW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem[req.rd_addr];
	end

	// shared comparator: one table entry against the block under search
	assign hit = (rd_data_q == key);

endmodule

[design/jcbc_core.sv]
module jcbc_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_new_scan,
	input  logic [15:0]             in_rec_type,
	input  logic [15:0]             in_rec_size,
	input  logic [31:0]             in_block,
	input  logic [16:0]             used_bytes,
	input  logic [6:0]              table_capacity,
	output logic                    out_valid,
	input  logic                    out_ready,
	output jcbc_pkg::result_t       out_res,
	output jcbc_pkg::tbl_req_t      tbl_req,
	output logic [31:0]             tbl_key,
	input  logic                    tbl_hit
);
	import jcbc_pkg::*;

	seq_state_t state_q, state_d;

	logic              new_q;
	logic [HalfW-1:0]  type_q;
	logic [HalfW-1:0]  size_q;
	logic [BlkW-1:0]   blk_q;

	logic [PosW-1:0]   pos_q;
	logic [CntW-1:0]   pend_cnt_q;
	logic [HeldW-1:0]  held_q;
	logic              stopped_q;

	logic [CntW-1:0]   walk_n_q;
	logic [PendW-1:0]  i_q;
	logic [TblW-1:0]   j_q;
	logic              full_q;
	logic [BlkW-1:0]   cur_blk_q;
	logic [BlkW-1:0]   pend_rd_q;
	logic [BlkW-1:0]   pend_mem [PendingDepth];

	result_t           res_q, res_d;
	logic              res_load;
	logic              out_valid_q;
	result_t           out_q;

	logic [PosW-1:0]   eff_pos;
	logic [CntW-1:0]   eff_cnt;
	logic [HeldW-1:0]  eff_held;
	logic              eff_stop;
	logic [PosW:0]     end_hdr;
	logic [PosW:0]     end_rec;
	logic [PosW:0]     used_ext;
	reason_t           chk_reason;
	logic              data_ok;
	logic              out_free;
	logic              is_last;
	logic [HeldW-1:0]  cap;
	logic              room;
	logic [TblW-1:0]   j_next;
	logic              j_end;

	assign eff_pos  = new_q ? SCAN_START : pos_q;
	assign eff_cnt  = new_q ? '0 : pend_cnt_q;
	assign eff_held = new_q ? '0 : held_q;
	assign eff_stop = new_q ? 1'b0 : stopped_q;

	assign end_hdr  = {1'b0, eff_pos} + (PosW+1)'(HDR_BYTES);
	assign end_rec  = {1'b0, eff_pos} + (PosW+1)'(size_q);
	assign used_ext = {1'b0, used_bytes};

	// header checks, in priority order
	always_comb begin
		chk_reason = RS_NONE;
		if (end_hdr > used_ext) begin
			chk_reason = RS_PAST_END;
		end else if (size_q < HDR_BYTES) begin
			chk_reason = RS_TOO_SMALL;
		end else if (end_rec > used_ext) begin
			chk_reason = RS_OVERRUN;
		end else if (type_q == TYPE_DATA) begin
			if (size_q != DATA_REC_BYTES) begin
				chk_reason = RS_BAD_SIZE;
			end else if (eff_cnt >= CntW'(PendingDepth)) begin
				chk_reason = RS_PEND_FULL;
			end
		end else if (type_q != TYPE_COMMIT) begin
			chk_reason = RS_UNKNOWN;
		end else if (size_q != HDR_BYTES) begin
			chk_reason = RS_BAD_SIZE;
		end
	end

	assign data_ok    = !eff_stop && (chk_reason == RS_NONE) && (type_q == TYPE_DATA);

	assign out_free = !out_valid_q || out_ready;
	assign is_last  = ({1'b0, i_q} + CntW'(1)) == walk_n_q;
	assign cap      = (table_capacity > TABLE_LIMIT) ? TABLE_LIMIT : table_capacity;
	assign room     = held_q < cap;
	assign j_next   = j_q + TblW'(1);
	assign j_end    = ({1'b0, j_q} + HeldW'(1)) == held_q;

	// sequencer: next state and the result being assembled
	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		res_load = 1'b0;
		in_ready = 1'b0;
		tbl_req.rd_addr = j_q;
		tbl_req.wr_en   = 1'b0;
		tbl_req.wr_addr = held_q[TblW-1:0];
		tbl_req.wr_data = cur_blk_q;
		case (state_q)
			SQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = SQ_CHECK;
				end
			end
			SQ_CHECK: begin
				res_load     = 1'b1;
				res_d.status = ST_IGNORED;
				res_d.reason = RS_NONE;
				res_d.block  = '0;
				res_d.pslot  = '0;
				res_d.tslot  = '0;
				res_d.held   = eff_held;
				res_d.last   = 1'b1;
				state_d      = SQ_EMIT;
				if (!eff_stop) begin
					if (chk_reason != RS_NONE) begin
						res_d.status = ST_STOPPED;
						res_d.reason = chk_reason;
					end else if (type_q == TYPE_DATA) begin
						res_d.status = ST_QUEUED;
						res_d.block  = blk_q;
						res_d.pslot  = eff_cnt[PendW-1:0];
					end else if (eff_cnt == '0) begin
						res_d.status = ST_EMPTY;
					end else begin
						res_load = 1'b0;
						state_d  = SQ_RD_PEND;
					end
				end
			end
			SQ_RD_PEND: begin
				state_d = SQ_LOAD_BLK;
			end
			SQ_LOAD_BLK: begin
				tbl_req.rd_addr = '0;
				if (full_q) begin
					res_load     = 1'b1;
					res_d.status = ST_DROPPED;
					res_d.reason = RS_NONE;
					res_d.block  = pend_rd_q;
					res_d.pslot  = i_q;
					res_d.tslot  = '0;
					res_d.held   = held_q;
					res_d.last   = is_last;
					state_d      = SQ_EMIT;
				end else if (held_q == '0) begin
					state_d = SQ_PLACE;
				end else begin
					state_d = SQ_SEARCH;
				end
			end
			SQ_SEARCH: begin
				tbl_req.rd_addr = j_next;
				if (tbl_hit) begin
					res_load     = 1'b1;
					res_d.status = ST_COMMITTED;
					res_d.reason = RS_NONE;
					res_d.block  = cur_blk_q;
					res_d.pslot  = i_q;
					res_d.tslot  = j_q;
					res_d.held   = held_q;
					res_d.last   = is_last;
					state_d      = SQ_EMIT;
				end else if (j_end) begin
					state_d = SQ_PLACE;
				end
			end
			SQ_PLACE: begin
				res_load     = 1'b1;
				res_d.reason = RS_NONE;
				res_d.block  = cur_blk_q;
				res_d.pslot  = i_q;
				res_d.last   = is_last;
				if (room) begin
					tbl_req.wr_en = 1'b1;
					res_d.status  = ST_COMMITTED;
					res_d.tslot   = held_q[TblW-1:0];
					res_d.held    = held_q + HeldW'(1);
				end else begin
					res_d.status  = ST_DROPPED;
					res_d.tslot   = '0;
					res_d.held    = held_q;
				end
				state_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				if (out_free) begin
					state_d = res_q.last ? SQ_IDLE : SQ_RD_PEND;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	assign tbl_key = cur_blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan state; a stopped scan leaves it alone until a new scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= SCAN_START;
			pend_cnt_q <= '0;
			held_q     <= '0;
			stopped_q  <= 1'b0;
			full_q     <= 1'b0;
			walk_n_q   <= '0;
			i_q        <= '0;
			j_q        <= '0;
		end else begin
			case (state_q)
				SQ_CHECK: begin
					if (!eff_stop) begin
						if (chk_reason != RS_NONE) begin
							pos_q      <= eff_pos;
							pend_cnt_q <= eff_cnt;
							held_q     <= eff_held;
							stopped_q  <= 1'b1;
						end else if (type_q == TYPE_DATA) begin
							pos_q      <= end_rec[PosW-1:0];
							pend_cnt_q <= eff_cnt + CntW'(1);
							held_q     <= eff_held;
							stopped_q  <= 1'b0;
						end else begin
							pos_q      <= end_hdr[PosW-1:0];
							pend_cnt_q <= '0;
							held_q     <= eff_held;
							stopped_q  <= 1'b0;
							walk_n_q   <= eff_cnt;
							i_q        <= '0;
							full_q     <= 1'b0;
						end
					end
				end
				SQ_LOAD_BLK: begin
					j_q <= '0;
				end
				SQ_SEARCH: begin
					j_q <= j_next;
				end
				SQ_PLACE: begin
					if (room) begin
						held_q <= held_q + HeldW'(1);
					end else begin
						full_q <= 1'b1;
					end
				end
				SQ_EMIT: begin
					if (out_free && !res_q.last) begin
						i_q <= i_q + PendW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// input transaction and per-entry work registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			new_q  <= in_new_scan;
			type_q <= in_rec_type;
			size_q <= in_rec_size;
			blk_q  <= in_block;
		end
		if (state_q == SQ_LOAD_BLK) begin
			cur_blk_q <= pend_rd_q;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// pending list
	always_ff @(posedge clk) begin
		if (state_q == SQ_CHECK && data_ok) begin
			pend_mem[eff_cnt[PendW-1:0]] <= blk_q;
		end
		pend_rd_q <= pend_mem[i_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == SQ_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

[design/journal_committed_block_collector_unit.sv]
// A data, empty-commit, stopped or ignored record gives one result, assembled in the check
//   state and moved to the output register once that is free. Commit: a check state, then
//   per pending entry a pending read, a block load, a compare of each held entry in turn
//   until a match, a place or drop if none matched, and the emit; once the table is full,
//   an entry is dropped straight from the load. One record at a time; s_tready is high only
//   while the sequencer is idle. Reset: arst_n resets sequencer, position (8), counts, registers.
module journal_committed_block_collector_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input record stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [15:0] rec_type, [31:16] rec_size, [63:32] block_number
	input  logic [0:0]  s_tuser,   // [0] new_scan
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] block_out, [36:32] pending_slot,
	                               // [42:37] table_slot, [49:43] entries_held, rest zero
	output logic [5:0]  m_tuser,   // [2:0] status, [5:3] stop_reason
	output logic        m_tlast,   // last result of the record
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import jcbc_pkg::*;

	logic [PosW-1:0]  used_bytes_q;
	logic [HeldW-1:0] table_cap_q;
	logic             cfg_wr;

	result_t          res;
	tbl_req_t         tbl_req;
	logic [BlkW-1:0]  tbl_key;
	logic             tbl_hit;

	// Registers sit one per word; only the word select bit decodes.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_bytes_q <= SCAN_START;
			table_cap_q  <= TABLE_LIMIT;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_USED_BYTES: used_bytes_q <= pwdata[PosW-1:0];
				REG_TABLE_CAP:  table_cap_q  <= pwdata[HeldW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_USED_BYTES: prdata = {{(32-PosW){1'b0}}, used_bytes_q};
			REG_TABLE_CAP:  prdata = {{(32-HeldW){1'b0}}, table_cap_q};
			default:        prdata = '0;
		endcase
	end

	// Sequencer, scan state, pending list and output register
	jcbc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_new_scan    (s_tuser[0]),
		.in_rec_type    (s_tdata[15:0]),
		.in_rec_size    (s_tdata[31:16]),
		.in_block       (s_tdata[63:32]),
		.used_bytes     (used_bytes_q),
		.table_capacity (table_cap_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_res        (res),
		.tbl_req        (tbl_req),
		.tbl_key        (tbl_key),
		.tbl_hit        (tbl_hit)
	);

	// Committed table with the shared block comparator on its registered read port
	jcbc_table u_table (
		.clk (clk),
		.req (tbl_req),
		.key (tbl_key),
		.hit (tbl_hit)
	);

	// Pack the held result onto the stream
	assign m_tdata = {6'b0, res.held, res.tslot, res.pslot, res.block};
	assign m_tuser = {res.reason, res.status};
	assign m_tlast = res.last;

endmodule

[design/jcbc_chk.sv]
module jcbc_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [5:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready
);
	import jcbc_pkg::*;

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// Take no second record straight after a transaction
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("record taken while busy");

	// Single-result records always close the record
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == ST_QUEUED || m_tuser[2:0] == ST_EMPTY
			|| m_tuser[2:0] == ST_STOPPED || m_tuser[2:0] == ST_IGNORED) |-> m_tlast)
		else $error("single result without last");

	// Only a stop carries a reason
	a_reason_only_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] != ST_STOPPED |-> m_tuser[5:3] == RS_NONE)
		else $error("reason on a non-stop result");

	// Table occupancy never exceeds its depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[49:43] <= TABLE_LIMIT)
		else $error("entries held out of range");

endmodule

bind journal_committed_block_collector_unit jcbc_chk u_jcbc_chk (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import jcbc_pkg::*;

	// Give up long after the slowest legal run could have finished.
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	// Tracks the journal scan the same way the block should, and holds the results that
	// each accepted record header is due to produce, oldest first.
	class replay_scoreboard;
		int unsigned used_bytes;
		int unsigned table_cap;
		int unsigned position;
		logic [BlkW-1:0] pending [PendingDepth];
		int unsigned pend_cnt;
		logic [BlkW-1:0] committed [TableDepth];
		int unsigned held;
		bit stopped;
		result_t awaited [$];
		int unsigned failures;

		function new();
			used_bytes = 8;
			table_cap  = 64;
			position   = 8;
			pend_cnt   = 0;
			held       = 0;
			stopped    = 1'b0;
			failures   = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_USED_BYTES)
				used_bytes = value & 32'h1_FFFF;
			else
				table_cap = value & 32'h7F;
		endfunction

		function void push(status_t st, reason_t why, logic [BlkW-1:0] blk,
				int unsigned ps, int unsigned ts, bit fin);
			result_t r;
			r.status = st;
			r.reason = why;
			r.block  = blk;
			r.pslot  = PendW'(ps);
			r.tslot  = TblW'(ts);
			r.held   = HeldW'(held);
			r.last   = fin;
			awaited.push_back(r);
		endfunction

		function void halt(reason_t why);
			stopped = 1'b1;
			push(ST_STOPPED, why, '0, 0, 0, 1'b1);
		endfunction

		// Work out every result an accepted record header causes and advance the scan.
		function void take_record(logic ns, logic [HalfW-1:0] rtype, logic [HalfW-1:0] rsize,
				logic [BlkW-1:0] blk);
			int unsigned cap;
			int unsigned slot;
			bit full;
			bit hit;
			if (ns) begin
				position = 8;
				pend_cnt = 0;
				held     = 0;
				stopped  = 1'b0;
			end
			if (stopped) begin
				push(ST_IGNORED, RS_NONE, '0, 0, 0, 1'b1);
				return;
			end
			if (position + 4 > used_bytes) begin
				halt(RS_PAST_END);
				return;
			end
			if (rsize < HDR_BYTES) begin
				halt(RS_TOO_SMALL);
				return;
			end
			if (position + rsize > used_bytes) begin
				halt(RS_OVERRUN);
				return;
			end
			if (rtype == TYPE_DATA) begin
				if (rsize != DATA_REC_BYTES) begin
					halt(RS_BAD_SIZE);
					return;
				end
				if (pend_cnt >= PendingDepth) begin
					halt(RS_PEND_FULL);
					return;
				end
				pending[pend_cnt] = blk;
				push(ST_QUEUED, RS_NONE, blk, pend_cnt, 0, 1'b1);
				pend_cnt++;
				position += rsize;
				return;
			end
			if (rtype != TYPE_COMMIT) begin
				halt(RS_UNKNOWN);
				return;
			end
			if (rsize != HDR_BYTES) begin
				halt(RS_BAD_SIZE);
				return;
			end
			cap = (table_cap < TableDepth) ? table_cap : TableDepth;
			if (pend_cnt == 0) begin
				push(ST_EMPTY, RS_NONE, '0, 0, 0, 1'b1);
			end else begin
				full = 1'b0;
				for (int i = 0; i < pend_cnt; i++) begin
					slot = 0;
					hit  = 1'b0;
					if (!full) begin
						for (int j = 0; j < held; j++) begin
							if (committed[j] == pending[i]) begin
								slot = j;
								hit  = 1'b1;
								break;
							end
						end
						if (!hit) begin
							if (held < cap) begin
								slot = held;
								committed[held] = pending[i];
								held++;
								hit = 1'b1;
							end else begin
								// once a new block meets a full table, drop the rest
								full = 1'b1;
							end
						end
					end
					if (hit)
						push(ST_COMMITTED, RS_NONE, pending[i], i, slot, i == pend_cnt - 1);
					else
						push(ST_DROPPED, RS_NONE, pending[i], i, 0, i == pend_cnt - 1);
				end
			end
			pend_cnt = 0;
			position += 4;
		endfunction

		function void compare(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				failures++;
				$display("%0t %s: expected %0h, got %0h", $time, what, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				failures++;
				$display("%0t unexpected result: expected none, got status %0d block %0h",
					$time, got.status, got.block);
				return;
			end
			want = awaited.pop_front();
			compare("status", want.status, got.status);
			compare("stop_reason", want.reason, got.reason);
			compare("block_out", want.block, got.block);
			compare("pending_slot", want.pslot, got.pslot);
			compare("table_slot", want.tslot, got.tslot);
			compare("entries_held", want.held, got.held);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;  // [15:0] rec_type, [31:16] rec_size, [63:32] block_number
	logic [0:0]  s_tuser  = '0;  // [0] new_scan
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // [31:0] block_out, [36:32] pending_slot,
	                             // [42:37] table_slot, [49:43] entries_held
	logic [5:0]  m_tuser;        // [2:0] status, [5:3] stop_reason
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	replay_scoreboard sb = new();

	// When set, neither side inserts gaps, so back-to-back transactions get exercised.
	bit calm = 1'b0;
	logic [BlkW-1:0] block_pool [6];
	int unsigned cycles = 0;

	journal_committed_block_collector_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run; the limit sits far beyond the slowest legal run.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[journal_committed_block_collector_unit] ERROR");
		$finish;
	end

	// Present one record header and hold it until the transaction completes; then draw the
	// gap before the next one. With no gap, tvalid simply stays high for the next record.
	task automatic send_record(input logic ns, input logic [HalfW-1:0] rtype,
			input logic [HalfW-1:0] rsize, input logic [BlkW-1:0] blk);
		int unsigned gap;
		s_tdata  <= {blk, rsize, rtype};
		s_tuser  <= ns;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.take_record(ns, rtype, rsize, blk);
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop tvalid and wait until every awaited result has arrived; then let the sequencer
	// return to idle before touching the registers.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Two-phase register write: setup phase, then access phase held until pready; afterwards
	// the bus idles before it is driven again.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Mostly well-formed data and commit headers over a small pool of block numbers, so
	// that commits hit existing table entries; the rest is malformed or random noise.
	task automatic random_record();
		logic ns;
		logic [HalfW-1:0] rtype;
		logic [HalfW-1:0] rsize;
		logic [BlkW-1:0] blk;
		int unsigned pick;
		ns = ($urandom_range(0, 15) == 0)
			|| (sb.stopped && $urandom_range(0, 3) != 0)
			|| (sb.position + DATA_REC_BYTES > sb.used_bytes && $urandom_range(0, 2) == 0);
		blk  = ($urandom_range(0, 4) == 0) ? $urandom() : block_pool[$urandom_range(0, 5)];
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			rtype = TYPE_DATA;
			rsize = DATA_REC_BYTES;
		end else if (pick < 75) begin
			rtype = TYPE_COMMIT;
			rsize = HDR_BYTES;
		end else if (pick < 82) begin
			rtype = TYPE_DATA;
			rsize = $urandom_range(0, 65535);
		end else if (pick < 88) begin
			rtype = TYPE_COMMIT;
			rsize = $urandom_range(0, 8);
		end else if (pick < 95) begin
			rtype = $urandom_range(0, 65535);
			rsize = $urandom_range(0, 1) ? HDR_BYTES : DATA_REC_BYTES;
		end else begin
			rtype = $urandom_range(0, 65535);
			rsize = $urandom_range(0, 65535);
		end
		send_record(ns, rtype, rsize, blk);
	endtask

	// Result side: draw a stall before each result, then accept and check it.
	initial begin : result_sink
		result_t got;
		int unsigned stall;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
			got.status = status_t'(m_tuser[2:0]);
			got.reason = reason_t'(m_tuser[5:3]);
			got.block  = m_tdata[31:0];
			got.pslot  = m_tdata[36:32];
			got.tslot  = m_tdata[42:37];
			got.held   = m_tdata[49:43];
			got.last   = m_tlast;
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		int unsigned n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings leave only eight bytes in use: the first header runs past the end
		// and everything after it is ignored.
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'h1234_5678);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);
		settle();
		write_reg(REG_USED_BYTES, 32'd65536);
		write_reg(REG_TABLE_CAP, 32'd64);

		// Empty commit, extreme block numbers, a duplicate upserted to its old slot.
		send_record(1'b1, TYPE_COMMIT, HDR_BYTES, '0);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'h0000_0000);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'hFFFF_FFFF);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'h0000_0000);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);
		// Each stop reason reachable with a full journal, plus a record after a stop.
		send_record(1'b0, TYPE_DATA, 16'd3, 32'h7);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'h7);
		send_record(1'b1, TYPE_DATA, DATA_REC_BYTES - 16'd1, 32'h7);
		send_record(1'b1, TYPE_COMMIT, HDR_BYTES + 16'd1, '0);
		send_record(1'b1, 16'h0000, HDR_BYTES, '0);
		send_record(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_record(1'b1, TYPE_DATA, 16'd0, '0);

		// One-entry table: a new block meets the full table and the rest are dropped.
		settle();
		write_reg(REG_TABLE_CAP, 32'd1);
		send_record(1'b1, TYPE_DATA, DATA_REC_BYTES, 32'hA5A5_0001);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'h5A5A_0002);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'hA5A5_0001);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'hA5A5_0001);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);

		// Journal sized for exactly one data record and one commit; zero table capacity.
		settle();
		write_reg(REG_USED_BYTES, 32'd4116);
		write_reg(REG_TABLE_CAP, 32'd0);
		send_record(1'b1, TYPE_DATA, DATA_REC_BYTES, 32'h0BAD_CAFE);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);

		// Shrink the journal in the middle of a scan.
		settle();
		write_reg(REG_USED_BYTES, 32'd65536);
		write_reg(REG_TABLE_CAP, 32'd64);
		send_record(1'b1, TYPE_DATA, DATA_REC_BYTES, 32'h0000_1111);
		send_record(1'b0, TYPE_DATA, DATA_REC_BYTES, 32'h8000_2222);
		settle();
		write_reg(REG_USED_BYTES, 32'd12);
		send_record(1'b0, TYPE_COMMIT, HDR_BYTES, '0);

		// Random phases, each under its own register settings; a phase may carry on the
		// scan left by the one before.
		for (int p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: begin
					write_reg(REG_USED_BYTES, 32'd65536);
					write_reg(REG_TABLE_CAP, 32'd64);
				end
				1: begin
					write_reg(REG_USED_BYTES, 32'd65536);
					write_reg(REG_TABLE_CAP, $urandom_range(1, 6));
				end
				2: begin
					write_reg(REG_USED_BYTES, $urandom_range(8, 65536));
					write_reg(REG_TABLE_CAP, $urandom_range(0, 64));
				end
				3: begin
					write_reg(REG_USED_BYTES,
						8 + 4104 * $urandom_range(1, 15) + 4 * $urandom_range(0, 3));
					write_reg(REG_TABLE_CAP, 32'd0);
				end
				4: begin
					write_reg(REG_USED_BYTES, 32'd8);
					write_reg(REG_TABLE_CAP, 32'd64);
				end
				5: begin
					write_reg(REG_USED_BYTES, 32'd65536);
					write_reg(REG_TABLE_CAP, $urandom_range(7, 15));
				end
				6: begin
					write_reg(REG_USED_BYTES,
						8 + 4104 * $urandom_range(1, 15) + 4 * $urandom_range(0, 3));
					write_reg(REG_TABLE_CAP, $urandom_range(2, 10));
				end
				default: begin
					write_reg(REG_USED_BYTES, 32'd65536);
					write_reg(REG_TABLE_CAP, 32'd64);
				end
			endcase
			calm = (p == 3 || p == 6);
			foreach (block_pool[i])
				block_pool[i] = $urandom();
			// the minimum journal only ever stops the scan, so keep that phase short
			n = (p == 4) ? 8 : 36;
			repeat (n) random_record();
		end

		settle();
		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.awaited.size() == 0)
			$display("[journal_committed_block_collector_unit] OK");
		else
			$display("[journal_committed_block_collector_unit] ERROR");
		$finish;
	end

endmodule
